>>> rtl/rrtt_pkg.sv
package rrtt_pkg;

  // default sizing
  localparam int SLOTS_DEF      = 128;
  localparam int VALUE_BITS_DEF = 64;

  // slot table row geometry: each memory row carries this many slot states
  localparam int ROW_LANES = 32;
  localparam int LANE_BITS = 5;

  typedef enum logic [1:0] {
    FN_TICK   = 2'd0,
    FN_CREATE = 2'd1,
    FN_EXIT   = 2'd2,
    FN_JOIN   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_EXITED  = 2'd3
  } slot_st_t;

  typedef enum logic [1:0] {
    RES_OK   = 2'd0,
    RES_ERR  = 2'd1,
    RES_WAIT = 2'd2
  } res_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_SCAN_INIT_S,
    OP_SCAN_INIT_C,
    OP_SCAN_STEP,
    OP_RD_RUN,
    OP_RD_TGT,
    OP_RD_ZERO,
    OP_RD_PICK,
    OP_RD_EXV,
    OP_WR_RUN_EXIT,
    OP_WR_RUN_RUNNING,
    OP_WR_LEAVE,
    OP_WR_PICK,
    OP_WR_CREATE,
    OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    res_t   res;
    logic   take_jval;
  } cmd_t;

  typedef struct packed {
    logic     clr_last;
    func_t    func;
    logic     active_le1;
    logic     active_over;
    logic     tgt_bad;
    logic     found;
    logic     scan_end;
    slot_st_t code_zero;
    slot_st_t code_tgt;
    logic     out_free;
  } sts_t;

endpackage

>>> rtl/rrtt_ctrl.sv
module rrtt_ctrl import rrtt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_C_SCAN,
    S_C_WAIT,
    S_X_WAIT,
    S_J_WAIT,
    S_J_VAL,
    S_SCHED,
    S_L_WAIT,
    S_L_RUN,
    S_S_SCAN,
    S_S_LEAVE,
    S_S_PICK,
    S_S_WAIT,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  res_t   res_r, res_nxt;
  logic   jv_r, jv_nxt;
  dp_op_t op;

  // take a beat only when idle
  assign in_stall = (state_r != S_IDLE);

  assign cmd_o.op        = op;
  assign cmd_o.res       = res_r;
  assign cmd_o.take_jval = jv_r;

  // sequence each event through the datapath
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    jv_nxt    = jv_r;
    op        = OP_NONE;
    unique case (state_r)
      S_CLEAR: begin
        op = OP_CLR;
        if (sts_i.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          res_nxt   = RES_OK;
          jv_nxt    = 1'b0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.func)
          FN_TICK: state_nxt = S_SCHED;
          FN_CREATE: begin
            if (sts_i.active_over) begin
              res_nxt   = RES_ERR;
              state_nxt = S_FIN;
            end else begin
              op        = OP_SCAN_INIT_C;
              state_nxt = S_C_SCAN;
            end
          end
          FN_EXIT: begin
            op        = OP_RD_RUN;
            state_nxt = S_X_WAIT;
          end
          FN_JOIN: begin
            if (sts_i.tgt_bad) begin
              res_nxt   = RES_ERR;
              state_nxt = S_FIN;
            end else begin
              op        = OP_RD_TGT;
              state_nxt = S_J_WAIT;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_C_SCAN: begin
        if (sts_i.found) begin
          op        = OP_RD_PICK;
          state_nxt = S_C_WAIT;
        end else if (sts_i.scan_end) begin
          res_nxt   = RES_ERR;
          state_nxt = S_FIN;
        end else begin
          op = OP_SCAN_STEP;
        end
      end
      S_C_WAIT: begin
        op        = OP_WR_CREATE;
        state_nxt = S_FIN;
      end
      S_X_WAIT: begin
        op        = OP_WR_RUN_EXIT;
        state_nxt = S_SCHED;
      end
      S_J_WAIT: begin
        if (sts_i.code_tgt == ST_UNUSED) begin
          res_nxt   = RES_ERR;
          state_nxt = S_FIN;
        end else if (sts_i.code_tgt == ST_EXITED) begin
          op        = OP_RD_EXV;
          state_nxt = S_J_VAL;
        end else begin
          res_nxt   = RES_WAIT;
          state_nxt = S_SCHED;
        end
      end
      S_J_VAL: begin
        jv_nxt    = 1'b1;
        state_nxt = S_FIN;
      end
      S_SCHED: begin
        if (sts_i.active_le1) begin
          op        = OP_RD_ZERO;
          state_nxt = S_L_WAIT;
        end else begin
          op        = OP_SCAN_INIT_S;
          state_nxt = S_S_SCAN;
        end
      end
      S_L_WAIT: begin
        if (sts_i.code_zero == ST_EXITED) begin
          op        = OP_RD_RUN;
          state_nxt = S_L_RUN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_L_RUN: begin
        op        = OP_WR_RUN_RUNNING;
        state_nxt = S_FIN;
      end
      S_S_SCAN: begin
        if (sts_i.found) begin
          op        = OP_RD_RUN;
          state_nxt = S_S_LEAVE;
        end else if (sts_i.scan_end) begin
          state_nxt = S_FIN;
        end else begin
          op = OP_SCAN_STEP;
        end
      end
      S_S_LEAVE: begin
        op        = OP_WR_LEAVE;
        state_nxt = S_S_PICK;
      end
      S_S_PICK: begin
        op        = OP_RD_PICK;
        state_nxt = S_S_WAIT;
      end
      S_S_WAIT: begin
        op        = OP_WR_PICK;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          op        = OP_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state and result code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      res_r   <= RES_OK;
      jv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
      jv_r    <= jv_nxt;
    end
  end

  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.op == OP_DONE) |-> sts_i.out_free)
    else $error("result written while output register is occupied");

  a_leave_after_find: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_S_SCAN && sts_i.found) |=> (cmd_o.op == OP_WR_LEAVE))
    else $error("switch did not release the previous slot");

  a_create_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.op == OP_WR_CREATE) |-> !sts_i.active_over)
    else $error("create committed with table over capacity");

endmodule

>>> rtl/rrtt_dp.sv
module rrtt_dp import rrtt_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_target_slot,
  input  logic [63:0] in_exit_value,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [6:0]  out_running_slot,
  output logic [6:0]  out_created_slot,
  output logic [63:0] out_join_value,
  input  cmd_t        cmd_i,
  output sts_t        sts_o
);

  localparam int ROWS     = (SLOTS + ROW_LANES - 1) / ROW_LANES;
  localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int XW       = RW + LANE_BITS;
  localparam int SW       = $clog2(SLOTS);
  localparam int IW       = $clog2(ROWS + 1);
  localparam int ROW_BITS = 2 * ROW_LANES;

  // storage
  logic [ROW_BITS-1:0]   st_mem [ROWS];
  logic [ROW_BITS-1:0]   row_rd_r;
  logic [VALUE_BITS-1:0] exv_mem [SLOTS];
  logic [VALUE_BITS-1:0] exv_rd_r;

  // thread state
  logic [XW-1:0] running_r;
  logic [7:0]    active_r;
  logic [RW-1:0] clr_row_r;

  // event beat
  func_t                 func_r;
  logic [7:0]            tgt_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [XW-1:0]         created_r;

  // scan
  logic [RW-1:0] iss_row_r, ev_row_r;
  logic [IW-1:0] iss_idx_r, ev_idx_r, last_r;
  logic          ev_valid_r, found_r, end_r, mode_c_r;
  logic [XW-1:0] pick_r;

  // result register
  logic        out_valid_r;
  res_t        out_status_r;
  logic [6:0]  out_run_r, out_created_r;
  logic [63:0] out_join_r;

  logic [RW-1:0]        run_row, tgt_row, pick_row;
  logic [LANE_BITS-1:0] run_lane, tgt_lane, pick_lane;
  logic [XW-1:0]        tgt_slot;
  slot_st_t             code_run, code_tgt;
  logic                 iss_ok, ev_live;

  logic                 rd_en;
  logic [RW-1:0]        rd_addr;
  logic                 wr_en;
  logic [RW-1:0]        wr_row;
  logic [LANE_BITS-1:0] wr_lane;
  slot_st_t             wr_code;
  logic [ROW_BITS-1:0]  wr_data;
  logic                 exv_en;
  logic [SW-1:0]        exv_addr;
  logic [VALUE_BITS-1:0] exv_data;

  logic [ROW_LANES-1:0] hit_vec;
  logic                 hit_any;
  logic [LANE_BITS-1:0] hit_lane;
  slot_st_t             want;

  assign run_row   = running_r[XW-1:LANE_BITS];
  assign run_lane  = running_r[LANE_BITS-1:0];
  assign tgt_slot  = XW'(tgt_r);
  assign tgt_row   = tgt_slot[XW-1:LANE_BITS];
  assign tgt_lane  = tgt_slot[LANE_BITS-1:0];
  assign pick_row  = pick_r[XW-1:LANE_BITS];
  assign pick_lane = pick_r[LANE_BITS-1:0];

  assign code_run = slot_st_t'(row_rd_r[{run_lane, 1'b0} +: 2]);
  assign code_tgt = slot_st_t'(row_rd_r[{tgt_lane, 1'b0} +: 2]);

  assign iss_ok  = (iss_idx_r <= last_r);
  assign ev_live = ev_valid_r && !found_r && !end_r;

  // match lanes of the row under evaluation
  always_comb begin
    want = mode_c_r ? ST_UNUSED : ST_READY;
    for (int l = 0; l < ROW_LANES; l++) begin
      hit_vec[l] = (row_rd_r[2*l +: 2] == want) &&
                   (32'({ev_row_r, LANE_BITS'(l)}) < 32'(SLOTS));
      if (mode_c_r) begin
        if (ev_row_r == '0 && l == 0) hit_vec[l] = 1'b0;
      end else if (ev_idx_r == '0) begin
        if (LANE_BITS'(l) <= run_lane) hit_vec[l] = 1'b0;
      end else if (ev_idx_r == last_r) begin
        if (LANE_BITS'(l) >= run_lane) hit_vec[l] = 1'b0;
      end
    end
  end

  // pick lowest matching lane
  always_comb begin
    hit_lane = '0;
    for (int l = ROW_LANES - 1; l >= 0; l--) begin
      if (hit_vec[l]) hit_lane = LANE_BITS'(l);
    end
  end
  assign hit_any = |hit_vec;

  // read port select
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (cmd_i.op)
      OP_RD_RUN:    begin rd_en = 1'b1; rd_addr = run_row;   end
      OP_RD_TGT:    begin rd_en = 1'b1; rd_addr = tgt_row;   end
      OP_RD_ZERO:   begin rd_en = 1'b1; rd_addr = '0;        end
      OP_RD_PICK:   begin rd_en = 1'b1; rd_addr = pick_row;  end
      OP_SCAN_STEP: begin rd_en = iss_ok; rd_addr = iss_row_r; end
      default:      rd_en = 1'b0;
    endcase
  end

  // write port select: read-modify-write of one lane; the clear sweep writes whole rows
  always_comb begin
    wr_en    = 1'b0;
    wr_row   = run_row;
    wr_lane  = run_lane;
    wr_code  = ST_RUNNING;
    exv_en   = 1'b0;
    exv_addr = running_r[SW-1:0];
    exv_data = val_r;
    unique case (cmd_i.op)
      OP_CLR: begin
        wr_en  = 1'b1;
        wr_row = clr_row_r;
      end
      OP_WR_RUN_EXIT: begin
        wr_en   = 1'b1;
        wr_code = ST_EXITED;
        exv_en  = (val_r != '0);
      end
      OP_WR_RUN_RUNNING: begin
        wr_en = 1'b1;
      end
      OP_WR_LEAVE: begin
        wr_en   = (code_run != ST_EXITED);
        wr_code = ST_READY;
      end
      OP_WR_PICK: begin
        wr_en   = 1'b1;
        wr_row  = pick_row;
        wr_lane = pick_lane;
      end
      OP_WR_CREATE: begin
        wr_en    = 1'b1;
        wr_row   = pick_row;
        wr_lane  = pick_lane;
        wr_code  = ST_READY;
        exv_en   = 1'b1;
        exv_addr = pick_r[SW-1:0];
        exv_data = '0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_comb begin
    if (cmd_i.op == OP_CLR) begin
      wr_data = (clr_row_r == '0) ? ROW_BITS'(ST_RUNNING) : '0;
    end else begin
      for (int l = 0; l < ROW_LANES; l++) begin
        wr_data[2*l +: 2] = (LANE_BITS'(l) == wr_lane) ? wr_code : row_rd_r[2*l +: 2];
      end
    end
  end

  // slot state table
  always_ff @(posedge clk) begin
    if (wr_en) st_mem[wr_row] <= wr_data;
    if (rd_en) row_rd_r <= st_mem[rd_addr];
  end

  // exit value table
  always_ff @(posedge clk) begin
    if (exv_en) exv_mem[exv_addr] <= exv_data;
    if (cmd_i.op == OP_RD_EXV) exv_rd_r <= exv_mem[tgt_slot[SW-1:0]];
  end

  // running slot, active count, clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
      active_r  <= 8'd1;
      clr_row_r <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_CLR:       clr_row_r <= clr_row_r + 1'b1;
        OP_WR_LEAVE: begin
          if (code_run == ST_EXITED && active_r != 8'd0) active_r <= active_r - 8'd1;
        end
        OP_WR_PICK:   running_r <= pick_r;
        OP_WR_CREATE: begin
          if (active_r != 8'hFF) active_r <= active_r + 8'd1;
        end
        default: ;
      endcase
    end
  end

  // latch the event beat
  always_ff @(posedge clk) begin
    if (cmd_i.op == OP_LOAD) begin
      func_r    <= func_t'(in_func);
      tgt_r     <= in_target_slot;
      val_r     <= in_exit_value[VALUE_BITS-1:0];
      created_r <= '0;
    end else if (cmd_i.op == OP_WR_CREATE) begin
      created_r <= pick_r;
    end
  end

  // scan flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
      found_r    <= 1'b0;
      end_r      <= 1'b0;
    end else if (cmd_i.op == OP_SCAN_INIT_S || cmd_i.op == OP_SCAN_INIT_C) begin
      ev_valid_r <= 1'b0;
      found_r    <= 1'b0;
      end_r      <= 1'b0;
    end else if (cmd_i.op == OP_SCAN_STEP) begin
      ev_valid_r <= iss_ok;
      if (ev_live) begin
        if (hit_any) found_r <= 1'b1;
        else if (ev_idx_r == last_r) end_r <= 1'b1;
      end
    end
  end

  // scan pointers: issue one row read, evaluate the previous one
  always_ff @(posedge clk) begin
    unique case (cmd_i.op)
      OP_SCAN_INIT_S: begin
        iss_row_r <= run_row;
        iss_idx_r <= '0;
        last_r    <= IW'(ROWS);
        mode_c_r  <= 1'b0;
      end
      OP_SCAN_INIT_C: begin
        iss_row_r <= '0;
        iss_idx_r <= '0;
        last_r    <= IW'(ROWS - 1);
        mode_c_r  <= 1'b1;
      end
      OP_SCAN_STEP: begin
        if (iss_ok) begin
          ev_row_r  <= iss_row_r;
          ev_idx_r  <= iss_idx_r;
          iss_idx_r <= iss_idx_r + 1'b1;
          iss_row_r <= (iss_row_r == RW'(ROWS - 1)) ? '0 : iss_row_r + 1'b1;
        end
        if (ev_live && hit_any) pick_r <= {ev_row_r, hit_lane};
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.op == OP_DONE) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.op == OP_DONE) begin
      out_status_r  <= cmd_i.res;
      out_run_r     <= 7'(running_r);
      out_created_r <= 7'(created_r);
      out_join_r    <= cmd_i.take_jval ? 64'(exv_rd_r) : 64'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_running_slot = out_run_r;
  assign out_created_slot = out_created_r;
  assign out_join_value   = out_join_r;

  // status to controller
  assign sts_o.clr_last    = (clr_row_r == RW'(ROWS - 1));
  assign sts_o.func        = func_r;
  assign sts_o.active_le1  = (active_r <= 8'd1);
  assign sts_o.active_over = ({24'd0, active_r} > 32'(SLOTS));
  assign sts_o.tgt_bad     = ({24'd0, tgt_r} >= 32'(SLOTS)) || (tgt_slot == running_r);
  assign sts_o.found       = found_r;
  assign sts_o.scan_end    = end_r;
  assign sts_o.code_zero   = slot_st_t'(row_rd_r[1:0]);
  assign sts_o.code_tgt    = code_tgt;
  assign sts_o.out_free    = !out_valid_r || !out_stall;

  a_scan_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(found_r && end_r))
    else $error("scan both found a slot and ran out");

  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(running_r) < 32'(SLOTS)))
    else $error("running slot outside table");

  a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (32'(pick_r) < 32'(SLOTS)))
    else $error("scan picked a padding lane");

endmodule

>>> rtl/round_robin_thread_table_unit.sv
// An event takes longest from accepted beat to registered result when an exit, or a join
// that must wait, switches threads, and is shortest for a bad join or a create past capacity;
// ROWS = ceil(SLOTS/32), so 4 rows at 128 slots.
// Throughput: one event at a time; the scan reads one 32-slot row of the state table a cycle.
// A finished result waits in the output register while the next beat is taken.
// Reset: after rst_n the state table is swept, one row a cycle (ROWS cycles), with in_stall high.
module round_robin_thread_table_unit import rrtt_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_target_slot,
  input  logic [63:0] in_exit_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [6:0]  out_running_slot,
  output logic [6:0]  out_created_slot,
  output logic [63:0] out_join_value
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  rrtt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  // tables, counters and result register
  rrtt_dp #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_func          (in_func),
    .in_target_slot   (in_target_slot),
    .in_exit_value    (in_exit_value),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_running_slot (out_running_slot),
    .out_created_slot (out_created_slot),
    .out_join_value   (out_join_value),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule
